// ----- sv/srt_pkg.sv -----
// srt_pkg: request and status codes, controller commands for sorted_region_table.
// No dependencies.
`default_nettype none
package srt_pkg;
  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0, REQ_REMOVE = 3'd1, REQ_LOOKUP = 3'd2, REQ_OVERLAP = 3'd3,
    REQ_GAP = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BAD_RANGE = 3'd1, ST_MISALIGNED = 3'd2, ST_PROT = 3'd3,
    ST_OVERLAP = 3'd4, ST_FULL = 3'd5, ST_NOT_FOUND = 3'd6, ST_NO_FIT = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN, S_WAIT, S_SHIFT, S_FINISH, S_OUT
  } state_e;

  localparam logic CFG_REGION_CAP = 1'b0;
  localparam logic CFG_CAP_EXEMPT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic check;     // run up-front checks
    logic rd_start;  // issue read of scan index
    logic step;      // evaluate registered read data
    logic shift;     // move one entry during insert or remove
    logic finish;    // final decision after scan
    logic out_take;  // result consumed
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic check_done;  // early result produced
    logic scan_done;   // scan result decided
    logic need_shift;  // table must be shifted
    logic shift_done;
  } sts_t;
endpackage
`default_nettype wire

// ----- sv/srt_ctrl.sv -----
// srt_ctrl: request sequencer for sorted_region_table.
// Depends on srt_pkg.
`default_nettype none
module srt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire srt_pkg::sts_t sts_i,
  output srt_pkg::cmd_t      cmd_o
);
  srt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= srt_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      srt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = srt_pkg::S_CHECK;
        end
      end
      srt_pkg::S_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.check_done) state_d = srt_pkg::S_OUT;
        else begin
          cmd_o.rd_start = 1'b1;
          state_d = srt_pkg::S_WAIT;
        end
      end
      srt_pkg::S_WAIT: state_d = srt_pkg::S_SCAN;
      srt_pkg::S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_done) state_d = srt_pkg::S_FINISH;
        else begin
          cmd_o.rd_start = 1'b1;
          state_d = srt_pkg::S_WAIT;
        end
      end
      srt_pkg::S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = sts_i.need_shift ? srt_pkg::S_SHIFT : srt_pkg::S_OUT;
      end
      srt_pkg::S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) state_d = srt_pkg::S_OUT;
      end
      srt_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.out_take = 1'b1;
          state_d = srt_pkg::S_IDLE;
        end
      end
      default: state_d = srt_pkg::S_IDLE;
    endcase
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_load_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == srt_pkg::S_CHECK) else $error("load lost");
endmodule
`default_nettype wire

// ----- sv/srt_dp.sv -----
// srt_dp: entry memory, scan datapath and result register for sorted_region_table.
// Depends on srt_pkg.
`default_nettype none
module srt_dp #(
  parameter int unsigned MAX_REGIONS = 64,
  parameter int unsigned ADDR_BITS   = 48,
  parameter int unsigned PAGE_BITS   = 12,
  localparam int unsigned IW = $clog2(MAX_REGIONS),
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire srt_pkg::cmd_t        cmd_i,
  output srt_pkg::sts_t             sts_o,
  input  wire logic [2:0]           req_type_i,
  input  wire logic [ADDR_BITS-1:0] addr_lo_i,
  input  wire logic [ADDR_BITS-1:0] addr_hi_i,
  input  wire logic [ADDR_BITS-1:0] gap_length_i,
  input  wire logic [2:0]           prot_i,
  input  wire logic [6:0]           region_cap_i,
  input  wire logic                 cap_exempt_i,
  output logic [2:0]                status_o,
  output logic                      hit_o,
  output logic [ADDR_BITS-1:0]      region_start_o,
  output logic [ADDR_BITS-1:0]      region_end_o,
  output logic [2:0]                region_prot_o,
  output logic [CW-1:0]             live_count_o
);
  localparam int unsigned EW = 2 * ADDR_BITS + 3;
  localparam logic [ADDR_BITS-1:0] PMASK = ADDR_BITS'((64'd1 << PAGE_BITS) - 64'd1);

  logic [EW-1:0] mem_q [MAX_REGIONS];
  logic [EW-1:0] rd_q;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  logic [2:0] req_q, prot_q;
  logic [ADDR_BITS-1:0] lo_q, hi_q, len_q, cand_q;
  logic [CW-1:0] total_q, idx_q, pos_q;
  logic found_q;     // set when the scan stops without a decision; for insert, a clean scan
  logic [2:0] st_q;
  logic hit_q;
  logic [ADDR_BITS-1:0] rs_q, re_q;
  logic [2:0] rp_q;
  logic scan_end_q;
  logic shift_rd_q;  // shift phase: read issued, write next

  logic [ADDR_BITS-1:0] es, ee;
  logic [2:0] ep;
  assign es = rd_q[ADDR_BITS-1:0];
  assign ee = rd_q[2*ADDR_BITS-1:ADDR_BITS];
  assign ep = rd_q[EW-1:2*ADDR_BITS];

  logic full_c;
  assign full_c = (!cap_exempt_i && 32'(total_q) >= 32'(region_cap_i)) ||
                  32'(total_q) >= MAX_REGIONS;

  // early checks
  logic [2:0] chk_st;
  logic chk_done;
  always_comb begin
    chk_st = srt_pkg::ST_OK;
    chk_done = 1'b0;
    priority case (req_q)
      srt_pkg::REQ_INSERT: begin
        if (lo_q >= hi_q) begin chk_done = 1'b1; chk_st = srt_pkg::ST_BAD_RANGE; end
        else if ((lo_q & PMASK) != '0 || (hi_q & PMASK) != '0) begin
          chk_done = 1'b1; chk_st = srt_pkg::ST_MISALIGNED;
        end else if ((prot_q[1] && prot_q[2]) || (prot_q[1] && !prot_q[0])) begin
          chk_done = 1'b1; chk_st = srt_pkg::ST_PROT;
        end
      end
      srt_pkg::REQ_OVERLAP:
        if (lo_q >= hi_q) begin chk_done = 1'b1; chk_st = srt_pkg::ST_BAD_RANGE; end
      srt_pkg::REQ_GAP: begin
        if (len_q == '0) begin chk_done = 1'b1; chk_st = srt_pkg::ST_BAD_RANGE; end
        else if ((len_q & PMASK) != '0 || (lo_q & PMASK) != '0 ||
                 (hi_q & PMASK) != '0) begin
          chk_done = 1'b1; chk_st = srt_pkg::ST_MISALIGNED;
        end else if (lo_q > hi_q) begin chk_done = 1'b1; chk_st = srt_pkg::ST_BAD_RANGE; end
        else if (hi_q - lo_q < len_q) begin chk_done = 1'b1; chk_st = srt_pkg::ST_NO_FIT; end
      end
      srt_pkg::REQ_REMOVE, srt_pkg::REQ_LOOKUP: ;
      default: begin chk_done = 1'b1; chk_st = srt_pkg::ST_BAD_RANGE; end
    endcase
  end

  // one scan step on registered entry idx_q (valid when idx_q < total)
  logic in_rng;
  logic s_done, s_found, s_stop;
  logic [2:0] s_st;
  logic [ADDR_BITS-1:0] s_cand;
  assign in_rng = idx_q < total_q;
  always_comb begin
    s_done = 1'b0; s_found = 1'b0; s_stop = 1'b0;
    s_st = srt_pkg::ST_OK; s_cand = cand_q;
    if (!in_rng) s_stop = 1'b1;
    else begin
      priority case (req_q)
        srt_pkg::REQ_INSERT:
          if (lo_q < ee && es < hi_q) begin s_done = 1'b1; s_st = srt_pkg::ST_OVERLAP; end
          else if (es >= hi_q) s_stop = 1'b1;
        srt_pkg::REQ_REMOVE:
          if (es == lo_q) begin s_done = 1'b1; s_found = 1'b1; end
        srt_pkg::REQ_LOOKUP:
          if (lo_q >= es && lo_q < ee) begin s_done = 1'b1; s_found = 1'b1; end
          else if (es > lo_q) s_stop = 1'b1;
        srt_pkg::REQ_OVERLAP:
          if (es >= hi_q) s_stop = 1'b1;
          else if (ee > lo_q) begin s_done = 1'b1; s_found = 1'b1; end
        default:
          if (ee > cand_q) begin
            if (es >= hi_q) s_stop = 1'b1;
            else if (es >= cand_q && es - cand_q >= len_q) begin
              s_done = 1'b1; s_found = 1'b1;
            end else s_cand = ee;
          end
      endcase
    end
  end

  logic last_shift;
  assign last_shift = (req_q == srt_pkg::REQ_INSERT) ? (idx_q == pos_q)
                                                      : (idx_q + 1'b1 >= total_q);

  always_comb begin
    rd_addr = IW'(idx_q);
    if (cmd_i.rd_start) rd_addr = IW'(cmd_i.check ? '0 : idx_q + 1'b1);
    if (cmd_i.shift && !shift_rd_q)
      rd_addr = (req_q == srt_pkg::REQ_INSERT) ? IW'(idx_q - 1'b1) : IW'(idx_q + 1'b1);
    wr_en = 1'b0;
    wr_addr = IW'(idx_q);
    wr_data = rd_q;
    if (cmd_i.shift && shift_rd_q) begin
      wr_en = 1'b1;
      if (req_q == srt_pkg::REQ_INSERT && idx_q == pos_q) wr_data = {prot_q, hi_q, lo_q};
    end
  end

  assign sts_o.check_done = chk_done;
  assign sts_o.scan_done  = s_done || s_stop;
  // a clean insert into a full table leaves the entries in place
  assign sts_o.need_shift = scan_end_q && !(req_q == srt_pkg::REQ_INSERT && full_c);
  assign sts_o.shift_done = cmd_i.shift && shift_rd_q && last_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0; scan_end_q <= 1'b0; shift_rd_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        scan_end_q <= 1'b0;
        if (req_q == srt_pkg::REQ_INSERT && found_q && !full_c) begin
          total_q <= total_q + 1'b1;
        end
      end
      if (cmd_i.shift) begin
        shift_rd_q <= !shift_rd_q;
        if (shift_rd_q && last_shift && req_q == srt_pkg::REQ_REMOVE)
          total_q <= total_q - 1'b1;
      end
      if (cmd_i.step && (s_done || s_stop)) begin
        // shifting needed on a clean insert scan, or on a remove hit
        scan_end_q <= (req_q == srt_pkg::REQ_INSERT && !s_done) ||
                      (req_q == srt_pkg::REQ_REMOVE && s_found);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i; lo_q <= addr_lo_i; hi_q <= addr_hi_i;
      len_q <= gap_length_i; prot_q <= prot_i; cand_q <= addr_lo_i;
      idx_q <= '0; found_q <= 1'b0;
    end
    if (cmd_i.check) begin
      st_q <= chk_st; hit_q <= 1'b0; rs_q <= '0; re_q <= '0; rp_q <= '0;
    end
    if (cmd_i.step) begin
      cand_q <= s_cand;
      if (s_done || s_stop) begin
        pos_q <= idx_q;
        found_q <= !s_done;  // insert: clean scan
        st_q <= s_st;
        if (s_found) begin
          hit_q <= 1'b1;
          if (req_q == srt_pkg::REQ_GAP) begin
            rs_q <= cand_q; re_q <= cand_q + len_q; rp_q <= '0;
          end else begin
            rs_q <= es; re_q <= ee; rp_q <= ep;
          end
        end
      end else idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.finish) begin
      priority case (req_q)
        srt_pkg::REQ_INSERT:
          if (found_q && full_c) st_q <= srt_pkg::ST_FULL;
        srt_pkg::REQ_GAP:
          if (!hit_q) begin
            if (cand_q < hi_q && hi_q - cand_q >= len_q) begin
              hit_q <= 1'b1; st_q <= srt_pkg::ST_OK;
              rs_q <= cand_q; re_q <= cand_q + len_q;
            end else st_q <= srt_pkg::ST_NO_FIT;
          end
        default:
          if (!hit_q && st_q == srt_pkg::ST_OK) st_q <= srt_pkg::ST_NOT_FOUND;
      endcase
      // insert shifts from the top down to pos; remove from match upward
      if (req_q == srt_pkg::REQ_INSERT) idx_q <= total_q;
    end
    if (cmd_i.shift && shift_rd_q && !last_shift)
      idx_q <= (req_q == srt_pkg::REQ_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
  end

  assign status_o = st_q;
  assign hit_o = hit_q;
  assign region_start_o = rs_q;
  assign region_end_o = re_q;
  assign region_prot_o = rp_q;
  assign live_count_o = total_q;

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(MAX_REGIONS)) else $error("count past storage");
  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q != $past(total_q) |-> (total_q == $past(total_q) + 1'b1 ||
    total_q == $past(total_q) - 1'b1)) else $error("count jumped");
endmodule
`default_nettype wire

// ----- sv/sorted_region_table.sv -----
// sorted_region_table: top level, config registers, controller and datapath.
// Depends on srt_pkg, srt_ctrl, srt_dp.
//
//  channel   | dir | words
//  s_axis    | in  | tdata {prot,gap_length,addr_hi,addr_lo}, tuser req_type
//  m_axis    | out | tdata {live_count,region_prot,region_end,region_start,hit,status}
//  cfg       | in  | cfg_index selects region_cap (0) or cap_exempt (1)
//
// A request rejected by the up-front checks goes accept, check, output; any
// other goes accept, check, then scan steps (each a registered memory read
// and a compare; the scan examines entries until it decides, one extra step
// when it runs off the end), finish, then a read and a write per entry moved
// on insert or remove, then output, which may be held by output stalls.
// One request is in flight; the input is held off until the result is taken.
// Reset clears the count and sets the config to a cap of 64, not exempt; entry memory needs no clearing pass.
`default_nettype none
module sorted_region_table #(
  parameter int unsigned MAX_REGIONS = 64,
  parameter int unsigned ADDR_BITS   = 48,
  parameter int unsigned PAGE_BITS   = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: addr_lo, addr_hi, gap_length, prot (low bit up), zero pad to bytes
  input  wire logic [((3*ADDR_BITS+3+7)/8)*8-1:0] s_axis_tdata,
  // tuser: req_type
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: status, hit, region_start, region_end, region_prot, live_count
  output logic [((2*ADDR_BITS+14+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IWB = ((3*ADDR_BITS+3+7)/8)*8;
  localparam int unsigned OWB = ((2*ADDR_BITS+14+7)/8)*8;

  logic [6:0] cap_q;
  logic       exempt_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 7'd64; exempt_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srt_pkg::CFG_REGION_CAP: cap_q <= cfg_data_i;
        srt_pkg::CFG_CAP_EXEMPT: exempt_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  srt_pkg::cmd_t cmd;
  srt_pkg::sts_t sts;

  srt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  logic [2:0] status, rprot;
  logic hit;
  logic [ADDR_BITS-1:0] rstart, rend;
  logic [CW-1:0] live;

  srt_dp #(.MAX_REGIONS(MAX_REGIONS), .ADDR_BITS(ADDR_BITS), .PAGE_BITS(PAGE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_type_i(s_axis_tuser),
    .addr_lo_i(s_axis_tdata[ADDR_BITS-1:0]),
    .addr_hi_i(s_axis_tdata[2*ADDR_BITS-1:ADDR_BITS]),
    .gap_length_i(s_axis_tdata[3*ADDR_BITS-1:2*ADDR_BITS]),
    .prot_i(s_axis_tdata[3*ADDR_BITS+2:3*ADDR_BITS]),
    .region_cap_i(cap_q), .cap_exempt_i(exempt_q),
    .status_o(status), .hit_o(hit), .region_start_o(rstart), .region_end_o(rend),
    .region_prot_o(rprot), .live_count_o(live)
  );

  assign m_axis_tdata = OWB'({7'(live), rprot, rend, rstart, hit, status});

  logic unused_pad;
  assign unused_pad = ^s_axis_tdata[IWB-1:3*ADDR_BITS+3];

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> s_axis_tready) else $error("config while busy");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("payload moved");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
endmodule
`default_nettype wire

// ----- bench/tb_sorted_region_table.sv -----
// tb_sorted_region_table: self-checking bench for the sorted region table.
// Needs srt_pkg and sorted_region_table; predicts every result word in SV.
`default_nettype none
module tb_sorted_region_table;
  localparam int NREG = 64;
  localparam logic [47:0] PGMASK = 48'hFFF;

  typedef struct {
    logic [2:0]  kind;
    logic [47:0] lo;
    logic [47:0] hi;
    logic [47:0] len;
    logic [2:0]  prot;
  } map_req_t;

  typedef struct {
    srt_pkg::status_e st;
    logic        hit;
    logic [47:0] r_start;
    logic [47:0] r_end;
    logic [2:0]  r_prot;
    logic [6:0]  cnt;
  } map_resp_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_index_i = 1'b0;
  logic [6:0]   cfg_data_i = '0;

  sorted_region_table u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the table and its registers
  logic [47:0] tbl_start [NREG];
  logic [47:0] tbl_end [NREG];
  logic [2:0]  tbl_prot [NREG];
  int          tbl_n = 0;
  int          cap_reg = 64;
  logic        exempt_reg = 1'b0;

  map_req_t  req_q [$];
  map_resp_t resp_q [$];
  map_req_t  tx_cur;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        n_err = 0;

  function automatic map_resp_t mk_resp(srt_pkg::status_e st, logic hit, logic [47:0] s,
                                        logic [47:0] e, logic [2:0] p);
    map_resp_t r;
    r.st = st; r.hit = hit; r.r_start = s; r.r_end = e; r.r_prot = p;
    r.cnt = 7'(tbl_n);
    return r;
  endfunction

  // computes the answer to one request and updates the shadow table
  function automatic map_resp_t serve_request(map_req_t q);
    int pos;
    logic [47:0] cand, s, e;
    logic [2:0] p;
    case (q.kind)
      srt_pkg::REQ_INSERT: begin
        if (q.lo >= q.hi) return mk_resp(srt_pkg::ST_BAD_RANGE, 0, 0, 0, 0);
        if ((q.lo & PGMASK) != 0 || (q.hi & PGMASK) != 0)
          return mk_resp(srt_pkg::ST_MISALIGNED, 0, 0, 0, 0);
        if (q.prot[1] && (q.prot[2] || !q.prot[0]))
          return mk_resp(srt_pkg::ST_PROT, 0, 0, 0, 0);
        pos = tbl_n;
        for (int i = 0; i < tbl_n; i++) begin
          if (q.lo < tbl_end[i] && tbl_start[i] < q.hi)
            return mk_resp(srt_pkg::ST_OVERLAP, 0, 0, 0, 0);
          if (tbl_start[i] >= q.hi) begin
            pos = i;
            break;
          end
        end
        if ((!exempt_reg && tbl_n >= cap_reg) || tbl_n >= NREG)
          return mk_resp(srt_pkg::ST_FULL, 0, 0, 0, 0);
        for (int i = tbl_n; i > pos; i--) begin
          tbl_start[i] = tbl_start[i-1];
          tbl_end[i] = tbl_end[i-1];
          tbl_prot[i] = tbl_prot[i-1];
        end
        tbl_start[pos] = q.lo; tbl_end[pos] = q.hi; tbl_prot[pos] = q.prot;
        tbl_n++;
        return mk_resp(srt_pkg::ST_OK, 0, 0, 0, 0);
      end
      srt_pkg::REQ_REMOVE: begin
        for (int i = 0; i < tbl_n; i++) begin
          if (tbl_start[i] == q.lo) begin
            s = tbl_start[i]; e = tbl_end[i]; p = tbl_prot[i];
            for (int j = i; j + 1 < tbl_n; j++) begin
              tbl_start[j] = tbl_start[j+1];
              tbl_end[j] = tbl_end[j+1];
              tbl_prot[j] = tbl_prot[j+1];
            end
            tbl_n--;
            return mk_resp(srt_pkg::ST_OK, 1, s, e, p);
          end
        end
        return mk_resp(srt_pkg::ST_NOT_FOUND, 0, 0, 0, 0);
      end
      srt_pkg::REQ_LOOKUP: begin
        for (int i = 0; i < tbl_n; i++) begin
          if (q.lo >= tbl_start[i] && q.lo < tbl_end[i])
            return mk_resp(srt_pkg::ST_OK, 1, tbl_start[i], tbl_end[i], tbl_prot[i]);
          if (tbl_start[i] > q.lo) break;
        end
        return mk_resp(srt_pkg::ST_NOT_FOUND, 0, 0, 0, 0);
      end
      srt_pkg::REQ_OVERLAP: begin
        if (q.lo >= q.hi) return mk_resp(srt_pkg::ST_BAD_RANGE, 0, 0, 0, 0);
        for (int i = 0; i < tbl_n; i++) begin
          if (tbl_start[i] >= q.hi) break;
          if (tbl_end[i] > q.lo)
            return mk_resp(srt_pkg::ST_OK, 1, tbl_start[i], tbl_end[i], tbl_prot[i]);
        end
        return mk_resp(srt_pkg::ST_NOT_FOUND, 0, 0, 0, 0);
      end
      srt_pkg::REQ_GAP: begin
        cand = q.lo;
        if (q.len == 0) return mk_resp(srt_pkg::ST_BAD_RANGE, 0, 0, 0, 0);
        if ((q.len & PGMASK) != 0 || (q.lo & PGMASK) != 0 || (q.hi & PGMASK) != 0)
          return mk_resp(srt_pkg::ST_MISALIGNED, 0, 0, 0, 0);
        if (q.lo > q.hi) return mk_resp(srt_pkg::ST_BAD_RANGE, 0, 0, 0, 0);
        if (q.hi - q.lo < q.len) return mk_resp(srt_pkg::ST_NO_FIT, 0, 0, 0, 0);
        for (int i = 0; i < tbl_n; i++) begin
          if (tbl_end[i] <= cand) continue;
          if (tbl_start[i] >= q.hi) break;
          if (tbl_start[i] >= cand && tbl_start[i] - cand >= q.len)
            return mk_resp(srt_pkg::ST_OK, 1, cand, cand + q.len, 0);
          cand = tbl_end[i];
        end
        if (cand < q.hi && q.hi - cand >= q.len)
          return mk_resp(srt_pkg::ST_OK, 1, cand, cand + q.len, 0);
        return mk_resp(srt_pkg::ST_NO_FIT, 0, 0, 0, 0);
      end
      default: return mk_resp(srt_pkg::ST_BAD_RANGE, 0, 0, 0, 0);
    endcase
  endfunction

  // sender: one word in flight, refilled from req_q
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) resp_q.push_back(serve_request(tx_cur));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          tx_cur = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'b0, tx_cur.prot, tx_cur.len, tx_cur.hi, tx_cur.lo};
          s_axis_tuser <= tx_cur.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string fld, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h want %h", fld, got, want);
    n_err++;
  endtask

  // receiver: checks each result word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    map_resp_t w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (resp_q.size() == 0) begin
          report_mismatch("unexpected word", 48'(m_axis_tdata[51:0]), 0);
        end else begin
          w = resp_q.pop_front();
          if (m_axis_tdata[2:0] != w.st) report_mismatch("status", m_axis_tdata[2:0], w.st);
          if (m_axis_tdata[3] != w.hit) report_mismatch("hit", m_axis_tdata[3], w.hit);
          if (m_axis_tdata[51:4] != w.r_start)
            report_mismatch("region_start", m_axis_tdata[51:4], w.r_start);
          if (m_axis_tdata[99:52] != w.r_end)
            report_mismatch("region_end", m_axis_tdata[99:52], w.r_end);
          if (m_axis_tdata[102:100] != w.r_prot)
            report_mismatch("region_prot", m_axis_tdata[102:100], w.r_prot);
          if (m_axis_tdata[109:103] != w.cnt)
            report_mismatch("live_count", m_axis_tdata[109:103], w.cnt);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  function automatic map_req_t mk_req(logic [2:0] kind, logic [47:0] lo, logic [47:0] hi,
                                      logic [47:0] len, logic [2:0] prot);
    map_req_t q;
    q.kind = kind; q.lo = lo; q.hi = hi; q.len = len; q.prot = prot;
    return q;
  endfunction

  // mostly page-aligned regions in a small window so the table fills and
  // requests collide; some words carry misaligned or full-width values
  function automatic map_req_t random_request();
    map_req_t q;
    int pick;
    pick = $urandom_range(99);
    q.kind = pick < 35 ? srt_pkg::REQ_INSERT : pick < 55 ? srt_pkg::REQ_REMOVE :
             pick < 70 ? srt_pkg::REQ_LOOKUP : pick < 82 ? srt_pkg::REQ_OVERLAP :
             pick < 95 ? srt_pkg::REQ_GAP : 3'($urandom_range(5, 7));
    q.lo = 48'($urandom_range(255)) << 12;
    q.hi = q.lo + (48'($urandom_range(1, 8)) << 12);
    q.len = 48'($urandom_range(1, 16)) << 12;
    q.prot = 3'($urandom_range(7));
    if (q.kind == srt_pkg::REQ_LOOKUP) q.lo = q.lo | 48'($urandom_range(4095));
    if (q.kind == srt_pkg::REQ_GAP) q.hi = q.lo + (48'($urandom_range(0, 64)) << 12);
    pick = $urandom_range(99);
    if (pick < 5) begin
      q.lo = rand48(); q.hi = rand48(); q.len = rand48();
    end else if (pick < 10) begin
      q.lo = q.lo | 48'($urandom_range(4095));
      q.len = q.len | 48'($urandom_range(4095));
    end else if (pick < 14) begin
      {q.lo, q.hi} = {q.hi, q.lo};
    end
    return q;
  endfunction

  task automatic cfg_write(logic idx, logic [6:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == srt_pkg::CFG_REGION_CAP) cap_reg = val;
    else exempt_reg = val[0];
  endtask

  // waits until the request queue is drained and every prediction is answered
  task automatic wait_idle();
    while (req_q.size() != 0 || s_axis_tvalid || resp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_idling(int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    cfg_write(srt_pkg::CFG_REGION_CAP, 7'd64);
    cfg_write(srt_pkg::CFG_CAP_EXEMPT, 1'b0);

    // directed: field extremes, each request kind and its error paths other than a full table
    req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'h0, 48'h1000, 0, 3'd1));
    req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'hFFFF_FFFF_E000, 48'hFFFF_FFFF_F000,
                           0, 3'd5));
    req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'h5000, 48'h5000, 0, 3'd1));
    req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'hFFFF_FFFF_FFFF, 48'h0, 0, 3'd1));
    req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'h5001, 48'h6000, 0, 3'd1));
    req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'h5000, 48'h6FFF, 0, 3'd1));
    req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'h5000, 48'h6000, 0, 3'd7));
    req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'h5000, 48'h6000, 0, 3'd2));
    req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'h5000, 48'h8000, 0, 3'd3));
    req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'h7000, 48'h9000, 0, 3'd1));
    req_q.push_back(mk_req(srt_pkg::REQ_LOOKUP, 48'h7FFF, 0, 0, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_LOOKUP, 48'h8000, 0, 0, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_OVERLAP, 48'h9000, 48'h9000, 0, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_OVERLAP, 48'h1000, 48'hFFFF_FFFF_FFFF, 0, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_OVERLAP, 48'h1000, 48'h5000, 0, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_GAP, 48'h0, 48'h10000, 48'h0, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_GAP, 48'h0, 48'h10000, 48'h1800, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_GAP, 48'h10000, 48'h0, 48'h1000, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_GAP, 48'h0, 48'h2000, 48'h3000, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_GAP, 48'h0, 48'hFFFF_FFFF_F000, 48'h4000, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_GAP, 48'h5000, 48'h8000, 48'h1000, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_REMOVE, 48'hFFFF_FFFF_E000, 0, 0, 0));
    req_q.push_back(mk_req(srt_pkg::REQ_REMOVE, 48'h6000, 0, 0, 0));
    req_q.push_back(mk_req(3'd5, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                           48'hFFFF_FFFF_FFFF, 3'd7));
    req_q.push_back(mk_req(3'd7, 0, 0, 0, 0));
    wait_idle();

    // small cap so full answers show up, sender mostly idle
    cfg_write(srt_pkg::CFG_REGION_CAP, 7'd3);
    set_idling(70, 0);
    repeat (60) req_q.push_back(random_request());
    wait_idle();

    // cap of zero: every valid insert is refused, receiver mostly stalled
    cfg_write(srt_pkg::CFG_REGION_CAP, 7'd0);
    set_idling(0, 70);
    repeat (30) req_q.push_back(random_request());
    wait_idle();

    // exempt: insert more regions than storage holds, then remove them again
    cfg_write(srt_pkg::CFG_REGION_CAP, 7'd64);
    cfg_write(srt_pkg::CFG_CAP_EXEMPT, 1'b1);
    set_idling(18, 18);
    for (int i = 0; i < 70; i++)
      req_q.push_back(mk_req(srt_pkg::REQ_INSERT, 48'(1024 + 2*i) << 12,
                             48'(1025 + 2*i) << 12, 0, 3'd1));
    for (int i = 0; i < 70; i++)
      req_q.push_back(mk_req(srt_pkg::REQ_REMOVE, 48'(1024 + 2*i) << 12, 0, 0, 0));
    wait_idle();

    // long mixed run, with and without idling
    cfg_write(srt_pkg::CFG_CAP_EXEMPT, 1'b0);
    cfg_write(srt_pkg::CFG_REGION_CAP, 7'd40);
    set_idling(0, 0);
    repeat (150) req_q.push_back(random_request());
    wait_idle();
    set_idling(18, 18);
    repeat (150) req_q.push_back(random_request());
    wait_idle();
    repeat (300) @(posedge clk_i);

    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

// ----- files.f -----
sv/srt_pkg.sv
sv/srt_ctrl.sv
sv/srt_dp.sv
sv/sorted_region_table.sv
bench/tb_sorted_region_table.sv
